// ----- design/mrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants of the minimal residual solver: field widths,
// input and configuration codes, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Field widths of the stream and configuration ports.
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int ITER_W = 16;
  localparam int SIZE_W = 7;
  localparam int TOL_W  = 32;
  localparam int OPC_W  = 2;
  localparam int CFG_W  = 2;

  // Input item kinds; the fourth code does nothing.
  localparam logic [OPC_W-1:0] OPC_LOAD_A = 2'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD_B = 2'd1;
  localparam logic [OPC_W-1:0] OPC_SOLVE  = 2'd2;
  localparam logic [OPC_W-1:0] OPC_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_W-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_LIMIT = 2'd1;
  localparam logic [CFG_W-1:0] CFG_TOL   = 2'd2;

  // Datapath operations, at most one issued per cycle by the controller.
  typedef enum logic [3:0] {
    OP_NOP,  // no operation
    OP_BSQ,  // clear x(i), accumulate b(i)^2
    OP_TSQ,  // tolerance squared
    OP_TH,   // one partial product of the convergence threshold
    OP_MVX,  // one term of A x
    OP_MVY,  // one term of A y
    OP_RES,  // y(i) = p(i) - b(i), accumulate y(i)^2
    OP_DOT,  // accumulate y(i) p(i)
    OP_PSQ,  // accumulate p(i)^2
    OP_DIV,  // start the step-length division
    OP_UPD,  // x(i) = x(i) - t y(i)
    OP_OUT   // emit x(i)
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [IDX_W-1:0]    r;      // row or element index
    logic [IDX_W-1:0]    c;      // column index, or partial select
    logic                first;  // first term of a sum
    logic                last;   // last term of a row, or last result
    logic [ITER_W-1:0]   iter;   // iteration count for results
    logic                conv;   // converged flag for results
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // command or pipeline or divider active
    logic bsq_zero;  // right-hand side is zero
    logic below;     // residual below threshold
    logic s2_zero;   // Ay . Ay is zero
    logic out_full;  // result register holds a beat
  } dp_stat_t;

  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;
  } ld_t;

endpackage

// ----- design/minimal_residual_solver_core.sv -----
// ----------------------------------------------------------------------------
// minimal_residual_solver_core
// Minimal residual solver for A x = b in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A load beat (matrix or right-hand entry) is taken whenever the block is
// idle. A solve sets up first and then runs full iterations: both
// matrix-vector products go through the single multiplier one term per
// cycle, reading the matrix memory at one address a cycle, each phase waits
// for the pipeline to drain, and the step length comes from a bit-serial
// divider. The n results follow one at a time, each once the one before has
// left the result register and the pipeline is empty. Input is refused from
// the start of a solve until the last result has been issued. No clearing
// pass runs after reset.
module minimal_residual_solver_core
  import mrs_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [47:0]         s_tdata,   // row [5:0], column [11:6], value [43:12]
  input  logic [OPC_W-1:0]    s_tuser,   // opcode [1:0]
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [55:0]         m_tdata,   // x_index [5:0], x_value [37:6], iterations [53:38]
  output logic                m_tuser,   // converged [0]
  output logic                m_tlast,
  // Configuration writes.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [SIZE_W-1:0]  system_size;
  logic [ITER_W-1:0]  iteration_limit;
  logic [TOL_W-1:0]   tolerance;
  logic               in_beat;
  logic [IDX_W-1:0]   in_row, in_col;
  ld_t                ld;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [IDX_W-1:0]   out_index;
  logic [VAL_W-1:0]   out_value;
  logic [ITER_W-1:0]  out_iter;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      system_size     <= SIZE_W'(64);
      iteration_limit <= ITER_W'(1000);
      tolerance       <= TOL_W'(42950);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE:  system_size     <= cfg_data[SIZE_W-1:0];
        CFG_LIMIT: iteration_limit <= cfg_data[ITER_W-1:0];
        CFG_TOL:   tolerance       <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat decode; loads outside the store are dropped.
  assign in_beat  = s_tvalid && s_tready;
  assign in_row   = s_tdata[5:0];
  assign in_col   = s_tdata[11:6];
  assign ld.row   = in_row;
  assign ld.col   = in_col;
  assign ld.value = s_tdata[43:12];
  assign ld.a_we  = in_beat && (s_tuser == OPC_LOAD_A) &&
                    (SIZE_W'(in_row) < SIZE_W'(MAX_SIZE)) &&
                    (SIZE_W'(in_col) < SIZE_W'(MAX_SIZE));
  assign ld.b_we  = in_beat && (s_tuser == OPC_LOAD_B) &&
                    (SIZE_W'(in_row) < SIZE_W'(MAX_SIZE));

  mrs_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk(clk), .rst(rst),
    .start(in_beat && (s_tuser == OPC_SOLVE)), .ready(s_tready),
    .system_size(system_size), .iteration_limit(iteration_limit),
    .stat(stat), .cmd(cmd)
  );

  mrs_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk(clk), .rst(rst), .ld(ld), .tolerance(tolerance),
    .cmd(cmd), .stat(stat),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_index(out_index), .out_value(out_value), .out_iter(out_iter),
    .out_conv(m_tuser), .out_last(m_tlast)
  );

  // Result packing.
  assign m_tdata = {2'b00, out_iter, out_value, out_index};

endmodule

// ----- design/mrs_ram.sv -----
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module mrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mrs_div.sv -----
// ----------------------------------------------------------------------------
// mrs_div
// Step-length divider: t = (num / den) in Q16.16, truncated toward zero and
// saturated. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrs_div
  import mrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  num,
  input  logic [63:0]         den,
  output logic                busy,
  output logic signed [31:0]  quot
);

  localparam int STEPS = 80;
  localparam int CNT_W = $clog2(STEPS);

  logic [CNT_W-1:0] cnt;
  logic [79:0]      dvd;
  logic [63:0]      rem;
  logic [63:0]      den_r;
  logic [31:0]      q;
  logic             ovf;
  logic             neg;
  logic [64:0]      trial;
  logic             ge;
  logic [63:0]      mag;

  assign mag   = num[63] ? (64'd0 - num) : num;
  assign trial = {rem, dvd[79]};
  assign ge    = trial >= {1'b0, den_r};

  // Control: count the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift-subtract datapath; any bit shifted out of the 32-bit quotient
  // marks a result that saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= {mag, 16'd0};
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
      neg   <= num[63];
      den_r <= den;
    end else if (busy) begin
      dvd <= {dvd[78:0], 1'b0};
      rem <= ge ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      q   <= {q[30:0], ge};
      ovf <= ovf | q[31];
    end
  end

  always_comb begin
    if (ovf || q[31]) begin
      quot = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      quot = neg ? -$signed(q) : $signed(q);
    end
  end

endmodule

// ----- design/mrs_dp.sv -----
// ----------------------------------------------------------------------------
// mrs_dp
// Solver datapath: the matrix and vector memories, a five-stage operation
// pipeline around one 33 x 33 multiplier, the sum registers and the divider.
// ----------------------------------------------------------------------------
module mrs_dp
  import mrs_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ld_t                 ld,
  input  logic [TOL_W-1:0]    tolerance,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_index,
  output logic [VAL_W-1:0]    out_value,
  output logic [ITER_W-1:0]   out_iter,
  output logic                out_conv,
  output logic                out_last
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] addu_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic signed [63:0] adds_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Pipeline command registers.
  dp_cmd_t c1, c2, c3, c4;

  // Memory ports.
  logic [AW-1:0]    a_raddr, a_waddr;
  logic [VAL_W-1:0] a_rdata, b_rdata, x_rdata, y_rdata, p_rdata;
  logic [IW-1:0]    x_raddr, y_raddr, x_waddr;
  logic [VAL_W-1:0] x_wdata, p_wdata;
  logic             x_we, y_we, p_we;

  // Arithmetic registers.
  logic signed [32:0] op_a, op_b, opa_r, opb_r;
  logic signed [31:0] ysat, y_s2, y_s3, x_s2, x_s3, x_new;
  logic [63:0]        prod;
  logic signed [65:0] mul;
  logic [63:0]        bsq, tsq, ysq, s2;
  logic signed [63:0] acc, s1;
  logic [127:0]       th_acc, th_term;
  logic signed [63:0] step;
  logic               div_busy;
  logic signed [31:0] t;

  // Memory address and write selection.
  assign a_raddr = AW'(AW'(cmd.r[IW-1:0]) * AW'(MAX_SIZE)) + AW'(cmd.c[IW-1:0]);
  assign a_waddr = AW'(AW'(ld.row[IW-1:0]) * AW'(MAX_SIZE)) + AW'(ld.col[IW-1:0]);
  assign x_raddr = (cmd.op == OP_MVX) ? cmd.c[IW-1:0] : cmd.r[IW-1:0];
  assign y_raddr = (cmd.op == OP_MVY) ? cmd.c[IW-1:0] : cmd.r[IW-1:0];

  always_comb begin
    x_we    = 1'b0;
    x_waddr = cmd.r[IW-1:0];
    x_wdata = '0;
    if (c3.op == OP_UPD) begin
      x_we    = 1'b1;
      x_waddr = c3.r[IW-1:0];
      x_wdata = x_new;
    end else if (cmd.op == OP_BSQ) begin
      x_we = 1'b1;
    end
  end

  assign y_we    = (c3.op == OP_RES);
  assign p_we    = ((c4.op == OP_MVX) || (c4.op == OP_MVY)) && c4.last;
  assign p_wdata = sat32(66'(acc >>> 16));

  mrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_a_ram (
    .clk(clk), .we(ld.a_we), .waddr(a_waddr), .wdata(ld.value),
    .raddr(a_raddr), .rdata(a_rdata)
  );
  mrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_b_ram (
    .clk(clk), .we(ld.b_we), .waddr(ld.row[IW-1:0]), .wdata(ld.value),
    .raddr(cmd.r[IW-1:0]), .rdata(b_rdata)
  );
  mrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );
  mrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(c3.r[IW-1:0]), .wdata(y_s3),
    .raddr(y_raddr), .rdata(y_rdata)
  );
  mrs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(c4.r[IW-1:0]), .wdata(p_wdata),
    .raddr(cmd.r[IW-1:0]), .rdata(p_rdata)
  );

  mrs_div u_div (
    .clk(clk), .rst(rst), .start(cmd.op == OP_DIV), .num(s1), .den(s2),
    .busy(div_busy), .quot(t)
  );

  // Command pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
    end else begin
      c1 <= cmd;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
    end
  end

  // Stage one: operand selection from the memory read data.
  assign ysat = sat32(66'(33'($signed(p_rdata)) - 33'($signed(b_rdata))));

  always_comb begin
    op_a = 33'($signed(a_rdata));
    op_b = 33'($signed(x_rdata));
    unique case (c1.op)
      OP_BSQ: begin
        op_a = 33'($signed(b_rdata));
        op_b = 33'($signed(b_rdata));
      end
      OP_TSQ: begin
        op_a = {1'b0, tolerance};
        op_b = {1'b0, tolerance};
      end
      OP_TH: begin
        op_a = {1'b0, c1.c[1] ? bsq[63:32] : bsq[31:0]};
        op_b = {1'b0, c1.c[0] ? tsq[63:32] : tsq[31:0]};
      end
      OP_MVY: op_b = 33'($signed(y_rdata));
      OP_RES: begin
        op_a = 33'(ysat);
        op_b = 33'(ysat);
      end
      OP_DOT: begin
        op_a = 33'($signed(y_rdata));
        op_b = 33'($signed(p_rdata));
      end
      OP_PSQ: begin
        op_a = 33'($signed(p_rdata));
        op_b = 33'($signed(p_rdata));
      end
      OP_UPD: begin
        op_a = 33'($signed(y_rdata));
        op_b = 33'(t);
      end
      default: ;
    endcase
  end

  // Stages one and two: operand registers, then the product register.
  assign mul = opa_r * opb_r;

  always_ff @(posedge clk) begin
    opa_r <= op_a;
    opb_r <= op_b;
    y_s2  <= ysat;
    x_s2  <= $signed(x_rdata);
    prod  <= mul[63:0];
    y_s3  <= y_s2;
    x_s3  <= x_s2;
  end

  // Stage three: sums and element updates.
  assign step  = $signed(prod) >>> 16;
  assign x_new = sat32(66'(x_s3) - 66'(step));

  always_comb begin
    unique case (c3.c[1:0])
      2'd0:    th_term = {64'd0, prod};
      2'd3:    th_term = {prod, 64'd0};
      default: th_term = {32'd0, prod, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (c3.op)
      OP_BSQ:         bsq    <= c3.first ? prod : addu_sat(bsq, prod);
      OP_TSQ:         tsq    <= prod;
      OP_TH:          th_acc <= (c3.first ? 128'd0 : th_acc) + th_term;
      OP_MVX, OP_MVY: acc    <= c3.first ? $signed(prod) : adds_sat(acc, $signed(prod));
      OP_RES:         ysq    <= c3.first ? prod : addu_sat(ysq, prod);
      OP_DOT:         s1     <= c3.first ? $signed(prod) : adds_sat(s1, $signed(prod));
      OP_PSQ:         s2     <= c3.first ? prod : addu_sat(s2, prod);
      default: ;
    endcase
  end

  // Result register, loaded from the solution memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c1.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c1.op == OP_OUT) begin
      out_index <= c1.r;
      out_value <= x_rdata;
      out_iter  <= c1.iter;
      out_conv  <= c1.conv;
      out_last  <= c1.last;
    end
  end

  // Status towards the controller.
  assign stat.busy = (cmd.op != OP_NOP) || (c1.op != OP_NOP) || (c2.op != OP_NOP) ||
                     (c3.op != OP_NOP) || (c4.op != OP_NOP) || div_busy;
  assign stat.bsq_zero = (bsq == 64'd0);
  assign stat.below    = (ysq < th_acc[127:64]);
  assign stat.s2_zero  = (s2 == 64'd0);
  assign stat.out_full = out_valid;

endmodule

// ----- design/mrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrs_ctrl
// Solver controller: walks the initialisation, threshold, iteration and
// result phases, issuing at most one datapath operation per cycle and waiting for
// the pipeline to drain between phases.
// ----------------------------------------------------------------------------
module mrs_ctrl
  import mrs_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                ready,
  input  logic [SIZE_W-1:0]   system_size,
  input  logic [ITER_W-1:0]   iteration_limit,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_TSQ, ST_TH, ST_LOOP, ST_MVX, ST_RES, ST_CHK,
    ST_MVY, ST_DOT, ST_SZ, ST_UPD, ST_EMIT, ST_DRAIN
  } state_t;

  state_t             state, ret;
  logic [IDX_W-1:0]   r, c, lidx;
  logic [1:0]         part;
  logic               sub;
  logic [ITER_W-1:0]  iter;
  logic               conv;
  logic [SIZE_W-1:0]  size_eff;

  // Size in use, clamped to the supported range.
  always_comb begin
    if (system_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (system_size > SIZE_W'(MAX_SIZE)) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end else begin
      size_eff = system_size;
    end
  end

  assign ready = (state == ST_IDLE);

  // Sequencer with registered command.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      cmd   <= '0;
      r     <= '0;
      c     <= '0;
      lidx  <= '0;
      part  <= '0;
      sub   <= 1'b0;
      iter  <= '0;
      conv  <= 1'b0;
    end else begin
      cmd <= '0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            lidx  <= IDX_W'(size_eff - 1'b1);
            r     <= '0;
            iter  <= '0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          cmd.op    <= OP_BSQ;
          cmd.r     <= r;
          cmd.first <= (r == '0);
          r         <= r + 1'b1;
          if (r == lidx) begin
            ret   <= ST_TSQ;
            state <= ST_DRAIN;
          end
        end
        ST_TSQ: begin
          if (stat.bsq_zero) begin
            conv  <= 1'b1;
            r     <= '0;
            state <= ST_EMIT;
          end else begin
            cmd.op <= OP_TSQ;
            part   <= '0;
            ret    <= ST_TH;
            state  <= ST_DRAIN;
          end
        end
        ST_TH: begin
          cmd.op    <= OP_TH;
          cmd.c     <= IDX_W'(part);
          cmd.first <= (part == 2'd0);
          part      <= part + 1'b1;
          if (part == 2'd3) begin
            ret   <= ST_LOOP;
            state <= ST_DRAIN;
          end
        end
        ST_LOOP: begin
          r <= '0;
          c <= '0;
          if (iter == iteration_limit) begin
            conv  <= 1'b0;
            state <= ST_EMIT;
          end else begin
            iter  <= iter + 1'b1;
            state <= ST_MVX;
          end
        end
        ST_MVX, ST_MVY: begin
          cmd.op    <= (state == ST_MVX) ? OP_MVX : OP_MVY;
          cmd.r     <= r;
          cmd.c     <= c;
          cmd.first <= (c == '0);
          cmd.last  <= (c == lidx);
          c         <= c + 1'b1;
          if (c == lidx) begin
            c <= '0;
            r <= r + 1'b1;
            if (r == lidx) begin
              r     <= '0;
              sub   <= 1'b0;
              ret   <= (state == ST_MVX) ? ST_RES : ST_DOT;
              state <= ST_DRAIN;
            end
          end
        end
        ST_RES: begin
          cmd.op    <= OP_RES;
          cmd.r     <= r;
          cmd.first <= (r == '0);
          r         <= r + 1'b1;
          if (r == lidx) begin
            ret   <= ST_CHK;
            state <= ST_DRAIN;
          end
        end
        ST_CHK: begin
          r <= '0;
          c <= '0;
          if (stat.below) begin
            conv  <= 1'b1;
            state <= ST_EMIT;
          end else begin
            state <= ST_MVY;
          end
        end
        ST_DOT: begin
          cmd.op    <= sub ? OP_PSQ : OP_DOT;
          cmd.r     <= r;
          cmd.first <= (r == '0);
          sub       <= ~sub;
          if (sub) begin
            r <= r + 1'b1;
            if (r == lidx) begin
              ret   <= ST_SZ;
              state <= ST_DRAIN;
            end
          end
        end
        ST_SZ: begin
          r <= '0;
          if (stat.s2_zero) begin
            conv  <= 1'b0;
            state <= ST_EMIT;
          end else begin
            cmd.op <= OP_DIV;
            ret    <= ST_UPD;
            state  <= ST_DRAIN;
          end
        end
        ST_UPD: begin
          cmd.op <= OP_UPD;
          cmd.r  <= r;
          r      <= r + 1'b1;
          if (r == lidx) begin
            ret   <= ST_LOOP;
            state <= ST_DRAIN;
          end
        end
        ST_EMIT: begin
          if (!stat.busy && !stat.out_full) begin
            cmd.op   <= OP_OUT;
            cmd.r    <= r;
            cmd.last <= (r == lidx);
            cmd.iter <= iter;
            cmd.conv <= conv;
            r        <= r + 1'b1;
            if (r == lidx) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DRAIN: begin
          if (!stat.busy) begin
            state <= ret;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/mrs_chk.sv -----
// ----------------------------------------------------------------------------
// mrs_chk
// Port checker for the solver: result handshake and result sequencing.
// ----------------------------------------------------------------------------
module mrs_chk
  import mrs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [55:0]         m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Input is refused while a solve still has results to issue.
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted during result emission");

  // Results are issued one at a time from the solution memory.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid)
    else $error("result beats issued back to back");

endmodule

bind minimal_residual_solver_core mrs_chk u_mrs_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ----- verif/mrs_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrs_checker
// Watches the configuration, input and result channels of the minimal
// residual solver. It keeps its own copy of the registers and stores, and on
// every solve beat it computes the solution in Q16.16 with the same
// saturating arithmetic. Each result beat is then compared with the oldest
// predicted element.
// ----------------------------------------------------------------------------
module mrs_checker
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          solves,
  output int          beats
);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  xval;
    logic [ITER_W-1:0] iter;
    logic              conv;
    logic              last;
  } x_elem_t;

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  // Own copy of the registers and stores.
  logic [SIZE_W-1:0] sys_size;
  logic [ITER_W-1:0] iter_limit;
  logic [TOL_W-1:0]  tol;
  int                mat [0:4095];
  int                rhs [0:63];
  int                xs  [0:63];
  int                ys  [0:63];
  int                ps  [0:63];
  x_elem_t           x_expected [$];

  function automatic longint add_sat_s(longint a, longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] add_sat_u(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  // Product of A with x (from_y = 0) or with y (from_y = 1) into ps.
  function automatic void mul_matrix(bit from_y, int n);
    longint acc;
    int     v;
    for (int r = 0; r < n; r++) begin
      acc = 0;
      for (int c = 0; c < n; c++) begin
        v = from_y ? ys[c] : xs[c];
        acc = add_sat_s(acc, longint'(mat[r*64+c]) * longint'(v));
      end
      ps[r] = clip32(acc >>> 16);
    end
  endfunction

  // Step length in Q16.16, truncated toward zero and saturated.
  function automatic int step_length(longint num, logic [63:0] den);
    logic [63:0] mag, q, r, res;
    mag = (num < 0) ? 64'd0 - num : num;
    q = mag / den;
    r = mag % den;
    if (q >= 64'd32768) return (num < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    res = q;
    for (int i = 0; i < 16; i++) begin
      res = res << 1;
      if (r >= den - r) begin
        res = res | 64'd1;
        r = r - (den - r);
      end else begin
        r = r + r;
      end
    end
    return (num < 0) ? -int'(res[31:0]) : int'(res[31:0]);
  endfunction

  // Full solve; queues one expected element per unknown.
  function automatic void solve_system();
    int           n, t, y;
    logic [63:0]  bsq, thresh, tol_sq, ysq, s2;
    logic [127:0] wide;
    longint       s1, p;
    logic [15:0]  count;
    bit           conv, done;
    x_elem_t      e;
    n = (sys_size == 0) ? 1 : (sys_size > 64) ? 64 : int'(sys_size);
    bsq = 0;
    for (int i = 0; i < n; i++) begin
      xs[i] = 0;
      bsq = add_sat_u(bsq, longint'(rhs[i]) * longint'(rhs[i]));
    end
    count = 0;
    conv = 0;
    done = 0;
    if (bsq == 0) begin
      conv = 1;
      done = 1;
    end
    tol_sq = {32'd0, tol} * {32'd0, tol};
    wide = {64'd0, bsq} * {64'd0, tol_sq};
    thresh = wide[127:64];
    for (int k = 0; k < int'(iter_limit) && !done; k++) begin
      count = k + 1;
      mul_matrix(0, n);
      ysq = 0;
      for (int i = 0; i < n; i++) begin
        y = clip32(longint'(ps[i]) - longint'(rhs[i]));
        ys[i] = y;
        ysq = add_sat_u(ysq, longint'(y) * longint'(y));
      end
      if (ysq < thresh) begin
        conv = 1;
        done = 1;
      end else begin
        mul_matrix(1, n);
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < n; i++) begin
          p = ps[i];
          s1 = add_sat_s(s1, longint'(ys[i]) * p);
          s2 = add_sat_u(s2, p * p);
        end
        if (s2 == 0) begin
          done = 1;
        end else begin
          t = step_length(s1, s2);
          for (int i = 0; i < n; i++)
            xs[i] = clip32(longint'(xs[i]) - ((longint'(ys[i]) * longint'(t)) >>> 16));
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      e.idx  = i;
      e.xval = xs[i];
      e.iter = count;
      e.conv = conv;
      e.last = (i == n - 1);
      x_expected.push_back(e);
    end
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    solves = 0;
    beats = 0;
    sys_size = 64;
    iter_limit = 1000;
    tol = 42950;
    for (int i = 0; i < 4096; i++) mat[i] = 0;
    for (int i = 0; i < 64; i++) begin
      rhs[i] = 0;
      xs[i] = 0;
    end
  end

  // Follow every accepted beat on the three channels.
  always @(posedge clk) begin
    x_elem_t got, want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIZE:  sys_size   = cfg_data[SIZE_W-1:0];
          CFG_LIMIT: iter_limit = cfg_data[ITER_W-1:0];
          CFG_TOL:   tol        = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OPC_LOAD_A: mat[s_tdata[5:0]*64 + s_tdata[11:6]] = s_tdata[43:12];
          OPC_LOAD_B: rhs[s_tdata[5:0]] = s_tdata[43:12];
          OPC_SOLVE: begin
            solve_system();
            solves++;
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        beats++;
        got = {m_tdata[5:0], m_tdata[37:6], m_tdata[53:38], m_tuser, m_tlast};
        if (x_expected.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = x_expected.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected idx %0d x %h iter %0d conv %b last %b",
                     $time, want.idx, want.xval, want.iter, want.conv, want.last);
            $display("%0t:                  actual   idx %0d x %h iter %0d conv %b last %b",
                     $time, got.idx, got.xval, got.iter, got.conv, got.last);
            errors++;
          end
        end
      end
      pending = x_expected.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the minimal residual solver. Directed systems cover the
// special cases (zero right-hand side, zero A y, zero iteration limit,
// extreme values and register settings), and random small systems close the
// run. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
  import mrs_pkg::*;
();

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // row [5:0], column [11:6], value [43:12]
  logic [1:0]  s_tuser = '0;  // opcode [1:0]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;       // x_index [5:0], x_value [37:6], iterations [53:38]
  logic        m_tuser;       // converged [0]
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors, pending, solves, beats;
  int items_sent = 0;
  int send_idle = 19;
  int recv_idle = 73;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  minimal_residual_solver_core i_dut (.*);

  mrs_checker i_checker (.*);

  always #6 clk = ~clk;

  initial begin
    #1_000_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Sink: random stalls, and a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_beat(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                           logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = op;
    s_tdata = {4'd0, value, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Wait until every predicted result has arrived and the block is quiet.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    s_tvalid = 0;
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  // Load an n by n system, diagonally weighted, with some noise between.
  task automatic load_system(int n, bit partial);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!partial || $urandom_range(2) == 0)
          send_beat(OPC_LOAD_A, 6'(r), 6'(c),
                    (r == c) ? pick_value() + (4 << 16) : pick_value());
        if ($urandom_range(7) == 0)
          send_beat($urandom_range(1) ? OPC_NONE : OPC_LOAD_A, 6'($urandom),
                    6'($urandom), $urandom);
      end
      if (!partial || $urandom_range(1) == 0)
        send_beat(OPC_LOAD_B, 6'(r), 6'($urandom), pick_value());
    end
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Diagonal system that converges under the widest iteration limit.
    write_reg(CFG_SIZE, 2);
    write_reg(CFG_LIMIT, 65535);
    write_reg(CFG_TOL, 42950);
    send_beat(OPC_LOAD_A, 0, 0, 1 << 16);
    send_beat(OPC_LOAD_A, 0, 1, 0);
    send_beat(OPC_LOAD_A, 1, 0, 0);
    send_beat(OPC_LOAD_A, 1, 1, 2 << 16);
    send_beat(OPC_LOAD_B, 0, 0, 1 << 16);
    send_beat(OPC_LOAD_B, 1, 0, -(3 << 16));
    send_beat(OPC_SOLVE, 0, 0, 0);
    // Zero right-hand side converges at once.
    send_beat(OPC_LOAD_B, 0, 0, 0);
    send_beat(OPC_LOAD_B, 1, 0, 0);
    send_beat(OPC_SOLVE, 63, 63, 32'hFFFF_FFFF);
    settle();
    // Unused opcode and unused top indexes, then a zero matrix (zero A y).
    send_beat(OPC_NONE, 63, 63, 32'hFFFF_FFFF);
    send_beat(OPC_LOAD_A, 63, 63, 32'h8000_0000);
    send_beat(OPC_LOAD_B, 63, 0, 32'h7FFF_FFFF);
    send_beat(OPC_LOAD_A, 0, 0, 0);
    send_beat(OPC_LOAD_A, 1, 1, 0);
    send_beat(OPC_LOAD_B, 0, 0, 5 << 16);
    send_beat(OPC_SOLVE, 0, 0, 0);
    settle();
    // Zero iteration limit.
    write_reg(CFG_LIMIT, 0);
    send_beat(OPC_SOLVE, 0, 0, 0);
    settle();
    // Extreme values with the widest tolerance.
    write_reg(CFG_LIMIT, 3);
    write_reg(CFG_TOL, 32'hFFFF_FFFF);
    send_beat(OPC_LOAD_A, 0, 0, 32'h7FFF_FFFF);
    send_beat(OPC_LOAD_A, 0, 1, 32'h8000_0000);
    send_beat(OPC_LOAD_A, 1, 0, 32'h8000_0000);
    send_beat(OPC_LOAD_A, 1, 1, 32'h7FFF_FFFF);
    send_beat(OPC_LOAD_B, 0, 0, 32'h8000_0000);
    send_beat(OPC_LOAD_B, 1, 0, 32'h7FFF_FFFF);
    send_beat(OPC_SOLVE, 0, 0, 0);
    settle();
    // Size zero acts as one, with zero tolerance.
    write_reg(CFG_TOL, 0);
    write_reg(CFG_SIZE, 0);
    send_beat(OPC_SOLVE, 0, 0, 0);
    settle();

    // Random small systems in three idling phases.
    write_reg(CFG_SIZE, 4);
    load_system(4, 0);
    for (int g = 0; items_sent < 110; g++) begin
      if (items_sent > 80) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (items_sent > 50) begin
        send_idle = 73;
        recv_idle = 19;
      end
      settle();
      n = $urandom_range(1, 4);
      write_reg(CFG_SIZE, n);
      write_reg(CFG_LIMIT, $urandom_range(1, 12));
      case ($urandom_range(3))
        0: write_reg(CFG_TOL, $urandom);
        1: write_reg(CFG_TOL, $urandom_range(0, 1 << 20));
        2: write_reg(CFG_TOL, 42950);
        default: ;
      endcase
      load_system(n, $urandom_range(3) == 0);
      if (g == 1) hold_req++;
      send_beat(OPC_SOLVE, 6'($urandom), 6'($urandom), $urandom);
      // Keep offering a beat while the results are held off.
      if (g == 1) send_beat(OPC_NONE, 0, 0, 0);
    end
    settle();
    repeat (100) @(posedge clk);

    $display("Sent %0d input beats, %0d solves; checked %0d solution beats.",
             items_sent, solves, beats);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
